@@ rtl/core/one_shot_trigger_bank_defines.svh @@
// Assertion macros for the one-shot trigger bank.
`ifndef ONE_SHOT_TRIGGER_BANK_DEFINES_SVH
`define ONE_SHOT_TRIGGER_BANK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define OTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OTB_ASSERT_IMP(lbl, ante, cons, msg) \
  `OTB_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle.
`define OTB_ASSERT_NXT(lbl, ante, cons, msg) \
  `OTB_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define OTB_ASSERT(lbl, prop, msg)
`define OTB_ASSERT_IMP(lbl, ante, cons, msg)
`define OTB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/otb_pkg.sv @@
// Shared types and constants of the one-shot trigger bank.
package otb_pkg;

  localparam int unsigned CHANNELS_DEF  = 8;
  localparam int unsigned TICK_BITS_DEF = 16;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  trigger_index;
    logic [15:0] tick_count;
    logic        arm;
  } in_t;

  typedef struct packed {
    logic       fired;
    logic [2:0] fired_index;
    logic       last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic set;        // write one channel from the request
    logic tick;       // count down every nonzero channel, capture the fire vector
    logic advance;    // step the scan one channel
    logic emit_null;  // load a fired=0 result
    logic emit_fire;  // load a fired=1 result for the current channel
  } cmd_t;

  typedef struct packed {
    logic pend_empty;
    logic pend_bit0;
    logic rest_empty;
    logic slot_free;
  } sts_t;

endpackage

@@ rtl/core/otb_ctrl.sv @@
// Control state machine of the one-shot trigger bank.
module otb_ctrl import otb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic op_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.slot_free && (op_i == OP_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.pend_empty) begin
          if (sts_i.slot_free) begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.pend_bit0 && sts_i.slot_free && sts_i.rest_empty) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.slot_free;
        if (in_valid_i && sts_i.slot_free) begin
          if (op_i == OP_TICK) begin
            cmd_o.tick = 1'b1;
          end else begin
            cmd_o.set       = 1'b1;
            cmd_o.emit_null = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.pend_empty) begin
          cmd_o.emit_null = sts_i.slot_free;
        end else if (!sts_i.pend_bit0) begin
          cmd_o.advance = 1'b1;
        end else if (sts_i.slot_free) begin
          cmd_o.emit_fire = 1'b1;
          cmd_o.advance   = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/otb_datapath.sv @@
// Channel counters, fire scan and result register of the one-shot trigger bank.
module otb_datapath import otb_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned TICK_BITS = TICK_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  req_i,
  input  logic out_ready_i,
  output sts_t sts_o,
  output logic out_valid_o,
  output out_t out_o
);

  localparam int unsigned PtrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TICK_BITS-1:0] cnt_q [CHANNELS];
  logic [CHANNELS-1:0]  armed_q;
  logic [CHANNELS-1:0]  fire_vec;
  logic [CHANNELS-1:0]  pend_q;
  logic [PtrW-1:0]      ptr_q;
  logic                 out_valid_q;
  out_t                 out_q;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic sel;
    logic near_zero;

    assign sel       = (int'(req_i.trigger_index) == i);
    // Zero or one now means zero after this tick.
    assign near_zero = (cnt_q[i] <= TICK_BITS'(1));
    assign fire_vec[i] = armed_q[i] && near_zero;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[i]   <= '0;
        armed_q[i] <= 1'b0;
      end else if (cmd_i.set && sel) begin
        cnt_q[i]   <= TICK_BITS'(req_i.tick_count);
        armed_q[i] <= req_i.arm;
      end else if (cmd_i.tick) begin
        if (cnt_q[i] != '0) begin
          cnt_q[i] <= cnt_q[i] - TICK_BITS'(1);
        end
        if (fire_vec[i]) begin
          armed_q[i] <= 1'b0;
        end
      end
    end
  end

  // Pending fire bits shift down as the scan pointer moves up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ptr_q  <= '0;
    end else if (cmd_i.tick) begin
      pend_q <= fire_vec;
      ptr_q  <= '0;
    end else if (cmd_i.advance) begin
      pend_q <= pend_q >> 1;
      ptr_q  <= ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_null || cmd_i.emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fire) begin
      out_q.fired       <= 1'b1;
      out_q.fired_index <= 3'(ptr_q);
      out_q.last        <= sts_o.rest_empty;
    end else if (cmd_i.emit_null) begin
      out_q.fired       <= 1'b0;
      out_q.fired_index <= 3'd0;
      out_q.last        <= 1'b1;
    end
  end

  assign sts_o.pend_empty = (pend_q == '0);
  assign sts_o.pend_bit0  = pend_q[0];
  assign sts_o.rest_empty = ((pend_q >> 1) == '0);
  assign sts_o.slot_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ rtl/core/one_shot_trigger_bank.sv @@
// Top level of the one-shot trigger bank: controller, datapath and checks.
// A set request's result is registered and valid in the cycle after acceptance.
// A tick first counts down and captures the fire vector, then scans one channel
// per cycle, stalling at a fired channel while the result register is full.
// Throughput: one set request per cycle while results drain freely.
// Reset (rst_ni, async, active low) zeroes all counts and armed flags.
`include "one_shot_trigger_bank_defines.svh"

module one_shot_trigger_bank import otb_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned TICK_BITS = TICK_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_res_o
);

  // Commands from the controller, status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshake. In idle it takes a request whenever
  // the result register is free or being drained; a tick moves it into the
  // scan state, which walks the captured fire vector low channel first.
  otb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_req_i.op),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // The datapath holds one count and armed flag per channel. A tick counts
  // every nonzero channel down at once, disarms armed channels that reach
  // zero and keeps their bits as the pending vector; the scan then shifts
  // it down one channel a cycle, held at a set bit while the result
  // register is full, and emits a result per set bit, last when no higher bit remains.
  otb_datapath #(
    .CHANNELS  (CHANNELS),
    .TICK_BITS (TICK_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_o       (out_res_o)
  );

  // A result with nothing fired always closes its request.
  `OTB_ASSERT_IMP(a_null_is_last, out_valid_o && !out_res_o.fired, out_res_o.last, "null result not last")
  // Never load a result into a register that still holds one.
  `OTB_ASSERT_IMP(a_emit_slot_free, cmd.emit_fire || cmd.emit_null, sts.slot_free, "result overwritten")
  // Hold off new requests while the scan is stepping.
  `OTB_ASSERT_IMP(a_no_ready_in_scan, cmd.advance, !in_ready_o, "request taken during scan")
  // An accepted tick always enters the scan.
  `OTB_ASSERT_NXT(a_tick_scans, in_valid_i && in_ready_o && (in_req_i.op == OP_TICK), !in_ready_o, "tick did not scan")

endmodule
